>>> rtl/prq_pkg.sv
// Package for the priority ready queue: sizes, command and status codes,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package prq_pkg;
  localparam int unsigned NumLevels  = 32;
  localparam int unsigned NumThreads = 32;
  localparam int unsigned LvlW = $clog2(NumLevels);
  localparam int unsigned ThrW = $clog2(NumThreads);
  localparam logic [5:0] LinkNone = 6'h3F;

  localparam logic [2:0] CmdInsTail  = 3'd0;
  localparam logic [2:0] CmdInsHead  = 3'd1;
  localparam logic [2:0] CmdRemove   = 3'd2;
  localparam logic [2:0] CmdFirst    = 3'd3;
  localparam logic [2:0] CmdSuspend  = 3'd4;

  localparam logic [2:0] StInserted  = 3'd0;
  localparam logic [2:0] StRefused   = 3'd1;
  localparam logic [2:0] StRemoved   = 3'd2;
  localparam logic [2:0] StFound     = 3'd3;
  localparam logic [2:0] StDropped   = 3'd4;
  localparam logic [2:0] StEmpty     = 3'd5;
  localparam logic [2:0] StError     = 3'd6;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic exec;    // perform one step (request or one first-ready step)
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic has_result; // step produced a result
    logic done;       // step finished the request
  } dp_stat_t;
endpackage

>>> rtl/priority_ready_queue.sv
// Priority ready queue, top level. A request is taken while the queue is
// idle and executed in the next cycle; its result shows in the cycle after.
// No new request is taken until the one before is done and its results taken.
// First-ready drops each suspended head in a step of its own, one list
// update per step, and shows each dropped head as a result.
// Reset clears level bitmap, queued and suspended marks; links need none.
`timescale 1ns / 1ps
module priority_ready_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [4:0] thread_id_i,
  input  logic [4:0] priority_req_i,
  input  logic       suspend_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [4:0] result_thread_o,
  output logic [4:0] result_priority_o,
  output logic       last_o
);
  prq_pkg::dp_cmd_t  dp_cmd;
  prq_pkg::dp_stat_t dp_stat;
  logic              res_load;

  // Sequence: accept request, execute steps, hold each result until taken.
  prq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(dp_cmd), .stat_i(dp_stat), .res_load_o(res_load)
  );

  // Lists, links, marks and the result register.
  prq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .stat_o(dp_stat), .res_load_i(res_load),
    .cmd_in_i(cmd_i), .thread_id_i, .priority_req_i, .suspend_value_i,
    .status_o, .result_thread_o, .result_priority_o, .last_o
  );
endmodule

>>> rtl/prq_ctrl.sv
// Controller for the priority ready queue: handshake and step sequencing.
// Depends on prq_pkg.
`timescale 1ns / 1ps
module prq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prq_pkg::dp_cmd_t  cmd_o,
  input  prq_pkg::dp_stat_t stat_i,
  output logic              res_load_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   more_q, more_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign res_load_o  = cmd_o.exec && stat_i.has_result;

  always_comb begin
    state_d = state_q;
    more_d  = more_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        more_d = !stat_i.done;
        if (stat_i.has_result) state_d = S_OUT;
        else if (stat_i.done) state_d = S_IDLE;
      end
      S_OUT: if (!out_stall_i) state_d = more_q ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EXEC))
    else $error("result shown without a step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> in_stall_o)
    else $error("input open while busy");
  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("accepted request not executed");
endmodule

>>> rtl/prq_dp.sv
// Datapath for the priority ready queue: per-level lists, links, marks and
// the result register. Depends on prq_pkg.
`timescale 1ns / 1ps
module prq_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prq_pkg::dp_cmd_t  cmd_i,
  output prq_pkg::dp_stat_t stat_o,
  input  logic              res_load_i,
  input  logic [2:0]        cmd_in_i,
  input  logic [4:0]        thread_id_i,
  input  logic [4:0]        priority_req_i,
  input  logic              suspend_value_i,
  output logic [2:0]        status_o,
  output logic [4:0]        result_thread_o,
  output logic [4:0]        result_priority_o,
  output logic              last_o
);
  localparam int unsigned NL = prq_pkg::NumLevels;
  localparam int unsigned NT = prq_pkg::NumThreads;
  localparam int unsigned LW = prq_pkg::LvlW;
  localparam int unsigned TW = prq_pkg::ThrW;

  logic [NL-1:0] nonempty_q, nonempty_d;
  logic [TW-1:0] head_q [NL];
  logic [TW-1:0] tail_q [NL];
  logic [5:0]    next_q [NT];
  logic [5:0]    prev_q [NT];
  logic [LW-1:0] qlvl_q [NT];
  logic [NT-1:0] inq_q, inq_d, susp_q, susp_d;

  logic [2:0] rcmd_q;
  logic [4:0] rtid_q, rpr_q;
  logic       rsv_q;

  logic [2:0] st_d, st_q;
  logic [4:0] th_d, th_q, pr_d, pr_q;
  logic       last_d, last_q;

  // link updates chosen combinationally
  logic          wh_en, wt_en, wn_en, wp_en, wn2_en, wp2_en, wq_en;
  logic [LW-1:0] wh_idx, wt_idx, wq_val;
  logic [TW-1:0] wh_val, wt_val;
  logic [TW-1:0] wn_idx, wp_idx, wn2_idx, wp2_idx;
  logic [5:0]    wn_val, wp_val, wn2_val, wp2_val;

  logic          tid_ok;
  logic [TW-1:0] tid;
  logic [LW-1:0] lvl;
  logic [LW-1:0] top;
  logic          any;
  logic [TW-1:0] h;
  logic [LW-1:0] ul;
  logic [5:0]    up, un;
  logic          up_ok, un_ok;

  assign tid_ok = ({1'b0, rtid_q} < 6'(NT));
  assign tid    = rtid_q[TW-1:0];
  assign lvl    = ({1'b0, rpr_q} >= 6'(NL)) ? LW'(NL - 1) : rpr_q[LW-1:0];

  always_comb begin
    top = '0;
    any = 1'b0;
    for (int i = 0; i < NL; i++) begin
      if (nonempty_q[i]) begin
        top = LW'(i);
        any = 1'b1;
      end
    end
  end

  assign h = head_q[top];

  always_comb begin
    nonempty_d = nonempty_q;
    inq_d  = inq_q;
    susp_d = susp_q;
    wh_en = 1'b0; wt_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
    wn2_en = 1'b0; wp2_en = 1'b0; wq_en = 1'b0;
    wh_idx = lvl; wt_idx = lvl; wq_val = lvl;
    wh_val = tid; wt_val = tid;
    wn_idx = tid; wp_idx = tid; wn2_idx = tid; wp2_idx = tid;
    wn_val = prq_pkg::LinkNone; wp_val = prq_pkg::LinkNone;
    wn2_val = prq_pkg::LinkNone; wp2_val = prq_pkg::LinkNone;
    st_d = prq_pkg::StError; th_d = '0; pr_d = '0; last_d = 1'b1;
    stat_o.has_result = 1'b1;
    stat_o.done = 1'b1;
    ul = '0; up = '0; un = '0; up_ok = 1'b0; un_ok = 1'b0;

    if (rcmd_q == prq_pkg::CmdFirst) begin
      if (!any) begin
        st_d = prq_pkg::StEmpty;
      end else begin
        th_d = 5'(h);
        pr_d = 5'(top);
        if (susp_q[h]) begin
          // drop suspended head and unlink it
          st_d = prq_pkg::StDropped;
          last_d = 1'b0;
          stat_o.done = 1'b0;
          un = next_q[h];
          un_ok = (un != prq_pkg::LinkNone) && (un < 6'(NT));
          wh_en = 1'b1; wh_idx = top; wh_val = un[TW-1:0];
          if (un_ok) begin
            wp_en = 1'b1; wp_idx = un[TW-1:0]; wp_val = prq_pkg::LinkNone;
          end else begin
            nonempty_d[top] = 1'b0;
          end
          inq_d[h] = 1'b0;
        end else begin
          st_d = prq_pkg::StFound;
        end
      end
    end else if (rcmd_q > prq_pkg::CmdSuspend) begin
      st_d = prq_pkg::StError;
    end else if (!tid_ok) begin
      th_d = rtid_q;
    end else if (rcmd_q == prq_pkg::CmdSuspend) begin
      susp_d[tid] = rsv_q;
      stat_o.has_result = 1'b0;
    end else if (rcmd_q == prq_pkg::CmdRemove) begin
      th_d = rtid_q;
      if (inq_q[tid]) begin
        ul = qlvl_q[tid];
        up = prev_q[tid];
        un = next_q[tid];
        up_ok = (up != prq_pkg::LinkNone) && (up < 6'(NT));
        un_ok = (un != prq_pkg::LinkNone) && (un < 6'(NT));
        st_d = prq_pkg::StRemoved;
        pr_d = 5'(ul);
        if (up_ok) begin
          wn_en = 1'b1; wn_idx = up[TW-1:0]; wn_val = un;
        end else begin
          wh_en = 1'b1; wh_idx = ul; wh_val = un[TW-1:0];
        end
        if (un_ok) begin
          wp_en = 1'b1; wp_idx = un[TW-1:0]; wp_val = up;
        end else begin
          wt_en = 1'b1; wt_idx = ul; wt_val = up[TW-1:0];
        end
        if (!up_ok && !un_ok) nonempty_d[ul] = 1'b0;
        inq_d[tid] = 1'b0;
      end
    end else begin
      th_d = rtid_q;
      if (susp_q[tid]) begin
        st_d = prq_pkg::StRefused;
        pr_d = 5'(lvl);
      end else if (!inq_q[tid]) begin
        st_d = prq_pkg::StInserted;
        pr_d = 5'(lvl);
        inq_d[tid] = 1'b1;
        wq_en = 1'b1;
        if (!nonempty_q[lvl]) begin
          nonempty_d[lvl] = 1'b1;
          wh_en = 1'b1; wt_en = 1'b1;
          wn_en = 1'b1; wp_en = 1'b1;
        end else if (rcmd_q == prq_pkg::CmdInsHead) begin
          wh_en = 1'b1;
          wn_en = 1'b1; wn_val = 6'(head_q[lvl]);
          wp_en = 1'b1;
          wp2_en = 1'b1; wp2_idx = head_q[lvl]; wp2_val = 6'(tid);
        end else begin
          wt_en = 1'b1;
          wp_en = 1'b1; wp_val = 6'(tail_q[lvl]);
          wn_en = 1'b1;
          wn2_en = 1'b1; wn2_idx = tail_q[lvl]; wn2_val = 6'(tid);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      inq_q      <= '0;
      susp_q     <= '0;
    end else if (cmd_i.exec) begin
      nonempty_q <= nonempty_d;
      inq_q      <= inq_d;
      susp_q     <= susp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rcmd_q <= cmd_in_i;
      rtid_q <= thread_id_i;
      rpr_q  <= priority_req_i;
      rsv_q  <= suspend_value_i;
    end
    if (cmd_i.exec) begin
      if (wh_en)  head_q[wh_idx]  <= wh_val;
      if (wt_en)  tail_q[wt_idx]  <= wt_val;
      if (wn_en)  next_q[wn_idx]  <= wn_val;
      if (wp_en)  prev_q[wp_idx]  <= wp_val;
      if (wn2_en) next_q[wn2_idx] <= wn2_val;
      if (wp2_en) prev_q[wp2_idx] <= wp2_val;
      if (wq_en)  qlvl_q[tid]     <= wq_val;
    end
    if (res_load_i) begin
      st_q <= st_d; th_q <= th_d; pr_q <= pr_d; last_q <= last_d;
    end
  end

  assign status_o          = st_q;
  assign result_thread_o   = th_q;
  assign result_priority_o = pr_q;
  assign last_o            = last_q;

  a_drop_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && st_d == prq_pkg::StDropped && stat_o.has_result) |-> !stat_o.done)
    else $error("dropped head marked final");
  a_inq_means_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inq_q == '0) |-> (nonempty_q == '0))
    else $error("level nonempty with no queued thread");
  a_susp_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && rcmd_q == prq_pkg::CmdSuspend && tid_ok) |-> !stat_o.has_result)
    else $error("suspend mark produced result");
endmodule
